[hw/rtl/alle_pkg.sv]
`timescale 1ns / 1ps

package alle_pkg;

    localparam int SLOT_COUNT = 64;
    localparam int VALUE_BITS = 32;
    localparam int SLOT_BITS  = $clog2(SLOT_COUNT);
    localparam int CNT_BITS   = $clog2(SLOT_COUNT + 1);

    typedef enum logic [2:0] {
        REQ_FIND   = 3'd0,
        REQ_APPEND = 3'd1,
        REQ_INS_AF = 3'd2,
        REQ_SORTED = 3'd3,
        REQ_DELETE = 3'd4,
        REQ_MAX    = 3'd5
    } req_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FREE,
        S_WALK_RD,
        S_WALK_CHK,
        S_PLACE,
        S_PLACE2,
        S_UNLINK,
        S_DONE
    } fsm_t;

    // controller to datapath
    typedef struct packed {
        logic load;         // capture request, reset walk
        logic free_start;   // restart free search
        logic free_step;    // test one free bit
        logic walk_rd;      // issue read of current node
        logic walk_adv;     // move to next node
        logic max_upd;      // take current as max
        logic hit_take;     // record current as hit
        logic write_node;   // write new node value/link, mark used
        logic link_prev;    // set prev link (or head) to new node
        logic unlink;       // remove hit node
        logic set_result;   // latch status/slot
        status_t status;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic free_done;
        logic free_found;
        logic walk_end;     // visited node_count nodes
        logic cur_eq_key;
        logic cur_eq_anc;
        logic cur_lt_key;
        logic max_lt_cur;
        logic list_empty;
        logic first_node;
    } dp_stat_t;

endpackage

[hw/rtl/array_linked_list_engine_unit.sv]
`timescale 1ns / 1ps
// channel | dir | tdata fields (low bit up)                      | tuser
// s_axis  | in  | req_type[2:0] key_value[34:3] anchor_value[66:35] | none
// m_axis  | out | status[1:0] slot[7:2] max_value[39:8]           | none
// one request at a time: accept, free search, decision, a read and a check per
// walked node, then place or answer, then hold the word until it is taken; the
// free-map scan and the node store set the rate
// reset clears head, node count and free map; node store needs no clearing
// a finished word waits in the output register; the next request is taken
// once that word has been taken

module array_linked_list_engine_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // req_type, key_value, anchor_value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // status, slot, max_value
);
    import alle_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic busy, done, in_fire;
    logic [1:0]  status;
    logic [5:0]  slot;
    logic signed [31:0] max_value;

    assign s_axis_tready = !busy;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = done;
    assign m_axis_tdata  = {max_value, slot, status};

    alle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .req_type (s_axis_tdata[2:0]),
        .out_free (m_axis_tready),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done)
    );

    alle_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .req_type     (s_axis_tdata[2:0]),
        .key_value    (s_axis_tdata[34:3]),
        .anchor_value (s_axis_tdata[66:35]),
        .stat         (stat),
        .status       (status),
        .slot         (slot),
        .max_value    (max_value)
    );

endmodule

[hw/rtl/alle_datapath.sv]
`timescale 1ns / 1ps

module alle_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  alle_pkg::dp_cmd_t                cmd,
    input  logic [2:0]                       req_type,
    input  logic signed [31:0]               key_value,
    input  logic signed [31:0]               anchor_value,
    output alle_pkg::dp_stat_t               stat,
    output logic [1:0]                       status,
    output logic [5:0]                       slot,
    output logic signed [31:0]               max_value
);
    import alle_pkg::*;

    logic [VALUE_BITS-1:0] val_mem [SLOT_COUNT];
    logic [SLOT_BITS-1:0]  link_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] free_reg;
    logic [SLOT_BITS-1:0]  head_reg;
    logic [CNT_BITS-1:0]   count_reg;

    logic [VALUE_BITS-1:0] key_reg, anc_reg, maxv_reg, rdv_reg;
    logic [SLOT_BITS-1:0]  rdl_reg;
    logic [2:0]            req_reg;
    logic [SLOT_BITS-1:0]  cur_reg, prev_reg, hit_reg, hprev_reg, max_slot_reg, new_reg;
    logic                  has_prev_reg, hhas_prev_reg;
    logic [CNT_BITS-1:0]   idx_reg, fidx_reg;
    logic                  free_found_reg;
    logic [1:0]            status_reg;
    logic [5:0]            slot_reg;
    logic [31:0]           max_out_reg;

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg      <= key_value[VALUE_BITS-1:0];
            anc_reg      <= anchor_value[VALUE_BITS-1:0];
            req_reg      <= req_type;
            cur_reg      <= head_reg;
            prev_reg     <= '0;
            has_prev_reg <= 1'b0;
            idx_reg      <= '0;
        end
        if (cmd.walk_rd)
        begin
            rdv_reg <= val_mem[cur_reg];
            rdl_reg <= link_mem[cur_reg];
        end
        if (cmd.max_upd)
        begin
            maxv_reg     <= rdv_reg;
            max_slot_reg <= cur_reg;
        end
        if (cmd.hit_take)
        begin
            hit_reg       <= cur_reg;
            hprev_reg     <= prev_reg;
            hhas_prev_reg <= has_prev_reg;
        end
        if (cmd.walk_adv)
        begin
            prev_reg     <= cur_reg;
            has_prev_reg <= 1'b1;
            cur_reg      <= rdl_reg;
            idx_reg      <= idx_reg + 1'b1;
        end
        if (cmd.free_start)
        begin
            fidx_reg <= '0;
        end
        else if (cmd.free_step && !free_found_reg)
        begin
            if (free_reg[fidx_reg[SLOT_BITS-1:0]])
                new_reg <= fidx_reg[SLOT_BITS-1:0];
            else
                fidx_reg <= fidx_reg + 1'b1;
        end
        if (cmd.write_node)
        begin
            val_mem[new_reg] <= key_reg;
            // insert after hit (req 2) or after walk prev, or at head
            if (req_reg == REQ_INS_AF)
                link_mem[new_reg] <= rdl_reg;
            else if (has_prev_reg && req_reg == REQ_SORTED)
                link_mem[new_reg] <= cur_reg;
            else if (req_reg == REQ_APPEND)
                link_mem[new_reg] <= head_reg;
            else
                link_mem[new_reg] <= head_reg;
        end
        if (cmd.link_prev)
        begin
            if (req_reg == REQ_INS_AF)
                link_mem[hit_reg] <= new_reg;
            else if (has_prev_reg)
                link_mem[prev_reg] <= new_reg;
        end
        if (cmd.unlink && hhas_prev_reg)
            link_mem[hprev_reg] <= rdl_reg;
        if (cmd.set_result)
        begin
            status_reg  <= cmd.status;
            slot_reg    <= '0;
            max_out_reg <= '0;
            if (cmd.status == ST_OK)
            begin
                unique case (req_reg)
                    REQ_FIND, REQ_DELETE: slot_reg <= 6'(hit_reg);
                    REQ_MAX:
                    begin
                        slot_reg    <= 6'(max_slot_reg);
                        max_out_reg <= 32'(signed'(maxv_reg));
                    end
                    default: slot_reg <= 6'(new_reg);
                endcase
            end
        end
    end

    // free search flag: fidx frozen on find
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            free_found_reg <= 1'b0;
        else if (cmd.free_start)
            free_found_reg <= 1'b0;
        else if (cmd.free_step && fidx_reg < CNT_BITS'(SLOT_COUNT)
                 && free_reg[fidx_reg[SLOT_BITS-1:0]])
            free_found_reg <= 1'b1;
    end

    // control state of the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg  <= '1;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.write_node)
            begin
                free_reg[new_reg] <= 1'b0;
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.link_prev && req_reg != REQ_INS_AF && !has_prev_reg)
                head_reg <= new_reg;
            if (cmd.unlink)
            begin
                free_reg[hit_reg] <= 1'b1;
                count_reg <= count_reg - 1'b1;
                if (!hhas_prev_reg)
                    head_reg <= (count_reg > CNT_BITS'(1)) ? rdl_reg : '0;
            end
        end
    end

    always_comb
    begin
        stat.free_found = free_found_reg;
        stat.free_done  = free_found_reg || fidx_reg == CNT_BITS'(SLOT_COUNT);
        stat.walk_end   = idx_reg == count_reg;
        stat.cur_eq_key = rdv_reg == key_reg;
        stat.cur_eq_anc = rdv_reg == anc_reg;
        stat.cur_lt_key = $signed(rdv_reg) < $signed(key_reg);
        stat.max_lt_cur = $signed(maxv_reg) < $signed(rdv_reg);
        stat.list_empty = count_reg == '0;
        stat.first_node = idx_reg == '0;
    end

    assign status    = status_reg;
    assign slot      = slot_reg;
    assign max_value = max_out_reg;

endmodule

[hw/rtl/alle_ctrl.sv]
`timescale 1ns / 1ps

module alle_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic [2:0]          req_type,
    input  logic                out_free,
    input  alle_pkg::dp_stat_t  stat,
    output alle_pkg::dp_cmd_t   cmd,
    output logic                busy,
    output logic                done
);
    import alle_pkg::*;

    fsm_t state_reg, state_next;
    logic [2:0] req_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            req_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire)
                req_reg <= req_type;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = ST_OK;
        busy       = 1'b1;
        done       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (in_fire)
                begin
                    cmd.load       = 1'b1;
                    cmd.free_start = 1'b1;
                    state_next     = S_FREE;
                end
            end
            S_FREE:
            begin
                // resolve empty, unused, free slot before walking
                priority if (req_reg > 3'(REQ_MAX))
                begin
                    cmd.set_result = 1'b1;
                    cmd.status = ST_NOTFOUND;
                    state_next = S_DONE;
                end
                else if (stat.list_empty && req_reg != 3'(REQ_APPEND)
                         && req_reg != 3'(REQ_SORTED))
                begin
                    cmd.set_result = 1'b1;
                    cmd.status = ST_EMPTY;
                    state_next = S_DONE;
                end
                else if (!stat.free_done)
                    cmd.free_step = 1'b1;
                else if (!stat.free_found && (req_reg == 3'(REQ_APPEND)
                         || req_reg == 3'(REQ_SORTED)))
                begin
                    cmd.set_result = 1'b1;
                    cmd.status = ST_FULL;
                    state_next = S_DONE;
                end
                else if (stat.walk_end)
                    state_next = S_PLACE;
                else
                begin
                    cmd.walk_rd = 1'b1;
                    state_next  = S_WALK_CHK;
                end
            end
            S_WALK_RD:
            begin
                if (stat.walk_end)
                begin
                    if (req_reg == 3'(REQ_APPEND) || req_reg == 3'(REQ_SORTED))
                        state_next = S_PLACE;
                    else if (req_reg == 3'(REQ_MAX))
                    begin
                        cmd.set_result = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.set_result = 1'b1;
                        cmd.status = ST_NOTFOUND;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    cmd.walk_rd = 1'b1;
                    state_next  = S_WALK_CHK;
                end
            end
            S_WALK_CHK:
            begin
                state_next = S_WALK_RD;
                unique case (req_reg)
                    3'(REQ_FIND):
                        if (stat.cur_eq_key)
                        begin
                            cmd.hit_take = 1'b1;
                            state_next = S_PLACE2;
                        end
                        else cmd.walk_adv = 1'b1;
                    3'(REQ_DELETE):
                        if (stat.cur_eq_key)
                        begin
                            cmd.hit_take = 1'b1;
                            state_next = S_UNLINK;
                        end
                        else cmd.walk_adv = 1'b1;
                    3'(REQ_INS_AF):
                        if (stat.cur_eq_anc)
                        begin
                            cmd.hit_take = 1'b1;
                            if (stat.free_found)
                                state_next = S_PLACE;
                            else
                            begin
                                cmd.set_result = 1'b1;
                                cmd.status = ST_FULL;
                                state_next = S_DONE;
                            end
                        end
                        else cmd.walk_adv = 1'b1;
                    3'(REQ_SORTED):
                        if (!stat.cur_lt_key) state_next = S_PLACE;
                        else cmd.walk_adv = 1'b1;
                    3'(REQ_MAX):
                    begin
                        if (stat.first_node || stat.max_lt_cur)
                            cmd.max_upd = 1'b1;
                        cmd.walk_adv = 1'b1;
                    end
                    default: cmd.walk_adv = 1'b1;  // append walks to the tail
                endcase
            end
            S_PLACE:
            begin
                cmd.write_node = 1'b1;
                state_next = S_PLACE2;
            end
            S_PLACE2:
            begin
                // link after write: the new node's link came from old state
                if (req_reg != 3'(REQ_FIND))
                    cmd.link_prev = 1'b1;
                cmd.set_result = 1'b1;
                state_next = S_DONE;
            end
            S_UNLINK:
            begin
                cmd.unlink = 1'b1;
                cmd.set_result = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                done = 1'b1;
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

[hw/rtl/alle_checker.sv]
`timescale 1ns / 1ps

module alle_props (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);
    // never take a request while a word is waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while output pending");

    // accepted request blocks further input next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second request accepted");

    // non-ok status carries slot zero and max zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[1:0] != 2'd0) |-> m_axis_tdata[39:2] == '0)
        else $error("failure result with nonzero payload");

    // stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed under stall");
endmodule

bind array_linked_list_engine_unit alle_props u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[sim/alle_checker.sv]
`timescale 1ns / 1ps

module alle_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,
    output int          fail_count,
    output int          pending_count,
    output int          result_count,
    output int          live_nodes
);
    import alle_pkg::*;

    typedef struct packed {
        logic [31:0] max_value;
        logic [5:0]  slot;
        status_t     status;
    } answer_t;

    logic signed [31:0] vals [SLOT_COUNT];
    logic [5:0]         links [SLOT_COUNT];
    logic               used [SLOT_COUNT];
    logic [5:0]         head;
    int                 count;
    answer_t            answers_due [$];

    function automatic int lowest_free();
        for (int i = 0; i < SLOT_COUNT; i++)
            if (!used[i])
                return i;
        return SLOT_COUNT;
    endfunction

    // walk for first node holding v
    function automatic bit locate(input logic signed [31:0] v, output int at,
                                  output int prv, output bit has_prv);
        int cur;
        cur = int'(head);
        prv = 0;
        at = 0;
        has_prv = 0;
        for (int i = 0; i < count; i++) begin
            if (vals[cur] == v) begin
                at = cur;
                has_prv = (i != 0);
                return 1;
            end
            prv = cur;
            cur = int'(links[cur]);
        end
        return 0;
    endfunction

    function automatic void link_in(input int k, input logic signed [31:0] v,
                                    input bit has_prv, input int prv);
        vals[k] = v;
        used[k] = 1'b1;
        if (!has_prv) begin
            links[k] = head;
            head = 6'(k);
        end else begin
            links[k] = links[prv];
            links[prv] = 6'(k);
        end
        count++;
    endfunction

    function automatic answer_t apply_request(input logic [71:0] d);
        logic [2:0]         req;
        logic signed [31:0] key, anc, mx;
        answer_t            a;
        int                 k, at, prv, cur;
        bit                 has_prv;
        req = d[2:0];
        key = d[34:3];
        anc = d[66:35];
        a = '{max_value: '0, slot: '0, status: ST_NOTFOUND};
        case (req)
            REQ_FIND:
                if (count == 0)
                    a.status = ST_EMPTY;
                else if (locate(key, at, prv, has_prv)) begin
                    a.status = ST_OK;
                    a.slot = 6'(at);
                end
            REQ_APPEND:
            begin
                k = lowest_free();
                if (k >= SLOT_COUNT)
                    a.status = ST_FULL;
                else begin
                    cur = int'(head);
                    for (int i = 1; i < count; i++)
                        cur = int'(links[cur]);
                    link_in(k, key, count != 0, cur);
                    a.status = ST_OK;
                    a.slot = 6'(k);
                end
            end
            REQ_INS_AF:
                if (count == 0)
                    a.status = ST_EMPTY;
                else if (locate(anc, at, prv, has_prv)) begin
                    k = lowest_free();
                    if (k >= SLOT_COUNT)
                        a.status = ST_FULL;
                    else begin
                        link_in(k, key, 1, at);
                        a.status = ST_OK;
                        a.slot = 6'(k);
                    end
                end
            REQ_SORTED:
            begin
                k = lowest_free();
                if (k >= SLOT_COUNT)
                    a.status = ST_FULL;
                else begin
                    cur = int'(head);
                    prv = 0;
                    has_prv = 0;
                    for (int i = 0; i < count; i++) begin
                        if (!(vals[cur] < key))
                            break;
                        prv = cur;
                        has_prv = 1;
                        cur = int'(links[cur]);
                    end
                    link_in(k, key, has_prv, prv);
                    a.status = ST_OK;
                    a.slot = 6'(k);
                end
            end
            REQ_DELETE:
                if (count == 0)
                    a.status = ST_EMPTY;
                else if (locate(key, at, prv, has_prv)) begin
                    if (!has_prv)
                        head = (count > 1) ? links[at] : 6'd0;
                    else
                        links[prv] = links[at];
                    used[at] = 1'b0;
                    count--;
                    a.status = ST_OK;
                    a.slot = 6'(at);
                end
            REQ_MAX:
                if (count == 0)
                    a.status = ST_EMPTY;
                else begin
                    cur = int'(head);
                    at = cur;
                    mx = vals[cur];
                    for (int i = 1; i < count; i++) begin
                        cur = int'(links[cur]);
                        if (mx < vals[cur]) begin
                            mx = vals[cur];
                            at = cur;
                        end
                    end
                    a.status = ST_OK;
                    a.slot = 6'(at);
                    a.max_value = mx;
                end
            default: ;
        endcase
        return a;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    assign pending_count = answers_due.size();
    assign live_nodes = count;

    always @(posedge clk or negedge rst_n)
    begin
        answer_t exp_a, got_a;
        if (!rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++)
                used[i] = 1'b0;
            head = '0;
            count = 0;
            fail_count = 0;
            result_count = 0;
            answers_due.delete();
        end else begin
            // result side first so a same-edge request queues behind it
            if (m_axis_tvalid && m_axis_tready) begin
                got_a = m_axis_tdata;
                result_count++;
                if (answers_due.size() == 0)
                    report_mismatch("unexpected word", m_axis_tdata[31:0], 32'd0);
                else begin
                    exp_a = answers_due.pop_front();
                    if (got_a.status !== exp_a.status)
                        report_mismatch("status", 32'(got_a.status), 32'(exp_a.status));
                    if (got_a.slot !== exp_a.slot)
                        report_mismatch("slot", 32'(got_a.slot), 32'(exp_a.slot));
                    if (got_a.max_value !== exp_a.max_value)
                        report_mismatch("max_value", got_a.max_value, exp_a.max_value);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                answers_due.push_back(apply_request(s_axis_tdata));
        end
    end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
    import alle_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS   = 1150;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;   // req_type, key_value, anchor_value
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // status, slot, max_value

    int fail_count, pending_count, result_count, live_nodes;
    int idle_cycles;
    bit long_hold;     // receiver holds off while set
    bit hold_done;

    // small pool of values so finds, anchors and deletes often hit
    logic signed [31:0] pool [16];

    array_linked_list_engine_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    alle_checker list_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .fail_count   (fail_count),
        .pending_count(pending_count),
        .result_count (result_count),
        .live_nodes   (live_nodes)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // offer one request word and hold it until taken
    task automatic send_request(input req_t req, input logic signed [31:0] key,
                                input logic signed [31:0] anc);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, anc, key, req};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic drop_valid();
        s_axis_tvalid <= 1'b0;
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return 32'sh7fffffff;
            2: return 32'sh80000000;
            default: return pool[$urandom_range(0, 15)];
        endcase
    endfunction

    // receiver: random stalls, calm stretches, and one long hold
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (long_hold)
            m_axis_tready <= 1'b0;
        else if ((($urandom_range(0, 1023) < 300)) && ($urandom_range(0, 3) != 0))
            m_axis_tready <= ($urandom_range(0, 2) != 0);
        else
            m_axis_tready <= 1'b1;
    end

    // long hold-off, counted here, while the sender keeps offering
    initial
    begin
        long_hold = 0;
        hold_done = 0;
        wait (result_count >= 300);
        @(posedge clk);
        long_hold <= 1;
        repeat (400) @(posedge clk);
        long_hold <= 0;
        hold_done <= 1;
    end

    // watchdog on cycles with no accepted word
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int burst;
        req_t r;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        for (int i = 0; i < 16; i++)
            pool[i] = (i < 8) ? $signed(i - 4) : $signed($urandom);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty-list cases, unused codes, extremes, ties
        send_request(REQ_FIND, 5, 0);
        send_request(REQ_DELETE, 5, 0);
        send_request(REQ_MAX, 0, 0);
        send_request(REQ_INS_AF, 1, 2);
        send_request(req_t'(3'd6), 32'shffffffff, 32'shffffffff);
        send_request(req_t'(3'd7), 0, 0);
        send_request(REQ_APPEND, 32'sh7fffffff, 0);
        send_request(REQ_APPEND, 32'sh80000000, 0);
        send_request(REQ_SORTED, 0, 0);
        send_request(REQ_SORTED, 0, 0);
        send_request(REQ_INS_AF, 9, 32'sh80000000);
        send_request(REQ_INS_AF, 9, 12345);
        send_request(REQ_APPEND, 32'sh7fffffff, 0);
        send_request(REQ_MAX, 0, 0);
        send_request(REQ_FIND, 9, 0);
        send_request(REQ_FIND, 777, 0);
        send_request(REQ_DELETE, 32'sh7fffffff, 0);
        send_request(REQ_DELETE, 32'sh55555555, 0);
        send_request(REQ_FIND, 32'shaaaaaaaa, 32'sh55555555);
        // fill the store to reach the full status on each inserting kind
        for (int i = 0; i < 64; i++)
            send_request(REQ_APPEND, pick_value(), 0);
        send_request(REQ_SORTED, 1, 0);
        send_request(REQ_INS_AF, 1, 32'sh80000000);
        send_request(REQ_INS_AF, 1, 32'sh13572468);
        send_request(REQ_MAX, 0, 0);
        drop_valid();

        // pause until every expected word is back
        wait (pending_count == 0);
        @(posedge clk);

        for (int n = 0; n < RANDOM_ITEMS; )
        begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && n < RANDOM_ITEMS; b++, n++) begin
                // bias toward growth when short, deletes when long
                case ($urandom_range(0, 9))
                    0, 1: r = (live_nodes > 40) ? REQ_DELETE : REQ_APPEND;
                    2:    r = REQ_SORTED;
                    3:    r = REQ_INS_AF;
                    4, 5: r = REQ_DELETE;
                    6:    r = REQ_FIND;
                    7:    r = REQ_MAX;
                    8:    r = (live_nodes < 8) ? REQ_APPEND : REQ_DELETE;
                    default: r = ($urandom_range(0, 7) == 0) ?
                                 req_t'(3'($urandom_range(6, 7))) : REQ_SORTED;
                endcase
                send_request(r, pick_value(), pick_value());
            end
            if ($urandom_range(0, 2) != 0) begin
                drop_valid();
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
        drop_valid();

        wait (hold_done && pending_count == 0);
        repeat (200) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
